### hw/rtl/euler_to_rotation_matrix_unit_assert.svh
// Assertion macros for the Euler angle to rotation matrix unit.
`ifndef EULER_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define EULER_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define E2R_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define E2R_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define E2R_ASSERT_IMPL(label, clk, rst_n, prop)
`define E2R_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### hw/rtl/e2r_pkg.sv
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package e2r_pkg;
    localparam int AngleWidth     = 16;
    localparam int ElemFracBits   = 14;
    localparam int CordicStages   = 16;
    localparam int WorkFrac       = 30;
    localparam int WorkWidth      = 34;
    localparam int ZWidth         = 34;
    localparam logic signed [WorkWidth-1:0] CordicGain = 34'sd652032874;
    localparam int ProdLatency    = 4;
    localparam int Latency        = CordicStages + ProdLatency;

    typedef logic signed [WorkWidth-1:0] work_t;
    typedef logic signed [ZWidth-1:0]    zval_t;

    typedef struct packed {
        logic signed [AngleWidth-1:0] roll_angle;
        logic signed [AngleWidth-1:0] pitch_angle;
        logic signed [AngleWidth-1:0] yaw_angle;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } out_word_t;

    // Per-lane CORDIC cell state
    typedef struct packed {
        work_t x;
        work_t y;
        zval_t z;
        logic  flip;
    } lane_t;

    typedef struct packed {
        lane_t rx;
        lane_t ry;
        lane_t rz;
        logic  vld;
    } cell_t;

    function automatic zval_t atan_turn(input int i);
        zval_t t;
        unique case (i)
            0:  t = 34'sd536870912;  1:  t = 34'sd316933406;
            2:  t = 34'sd167458907;  3:  t = 34'sd85004756;
            4:  t = 34'sd42667331;   5:  t = 34'sd21354465;
            6:  t = 34'sd10679838;   7:  t = 34'sd5340245;
            8:  t = 34'sd2670163;    9:  t = 34'sd1335087;
            10: t = 34'sd667544;     11: t = 34'sd333772;
            12: t = 34'sd166886;     13: t = 34'sd83443;
            14: t = 34'sd41722;      15: t = 34'sd20861;
            16: t = 34'sd10430;      17: t = 34'sd5215;
            18: t = 34'sd2608;       19: t = 34'sd1304;
            20: t = 34'sd652;        21: t = 34'sd326;
            22: t = 34'sd163;        23: t = 34'sd81;
            24: t = 34'sd41;         25: t = 34'sd20;
            26: t = 34'sd10;         27: t = 34'sd5;
            28: t = 34'sd3;          29: t = 34'sd1;
            30: t = 34'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction

    // Q30 product with round half up
    function automatic work_t qmul(input work_t a, input work_t b);
        logic signed [2*WorkWidth-1:0] p;
        p = (2*WorkWidth)'(a) * (2*WorkWidth)'(b)
            + (2*WorkWidth)'(64'sd1 <<< (WorkFrac - 1));
        return WorkWidth'(p >>> WorkFrac);
    endfunction

    // Q30 to output element, rounded and clamped
    function automatic logic signed [15:0] to_elem(input work_t v);
        localparam int Sh = WorkFrac - ElemFracBits;
        logic signed [WorkWidth:0] r;
        logic signed [WorkWidth:0] one;
        one = (WorkWidth+1)'(1) <<< ElemFracBits;
        r = ((WorkWidth+1)'(v) + ((WorkWidth+1)'(1) <<< (Sh - 1))) >>> Sh;
        if (r > one)  r = one;
        if (r < -one) r = -one;
        return r[15:0];
    endfunction

    // Fold an angle into +-pi/2 and load the cell
    function automatic lane_t lane_load(input logic signed [AngleWidth-1:0] a);
        lane_t l;
        zval_t z;
        z = ZWidth'(a) <<< (32 - AngleWidth);
        l.flip = 1'b0;
        if (z > (ZWidth'(1) <<< 30) || z < -(ZWidth'(1) <<< 30)) begin
            z = (z > 0) ? z - (ZWidth'(1) <<< 31) : z + (ZWidth'(1) <<< 31);
            l.flip = 1'b1;
        end
        l.x = CordicGain;
        l.y = '0;
        l.z = z;
        return l;
    endfunction
endpackage

### hw/rtl/e2r_cell.sv
// ----------------------------------------------------------------------------
// e2r_cell
// One CORDIC micro-rotation for all three angles, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module e2r_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [4:0]       shift,
    input  e2r_pkg::cell_t   cell_in,
    output e2r_pkg::cell_t   cell_out
);
    e2r_pkg::cell_t cell_next;
    e2r_pkg::lane_t rx_reg;
    e2r_pkg::lane_t ry_reg;
    e2r_pkg::lane_t rz_reg;
    logic           vld_reg;
    e2r_pkg::zval_t ang;

    function automatic e2r_pkg::lane_t rotate(input e2r_pkg::lane_t l,
                                              input logic [4:0] s,
                                              input e2r_pkg::zval_t t);
        e2r_pkg::lane_t o;
        o = l;
        if (l.z >= 0) begin
            o.x = l.x - (l.y >>> s);
            o.y = l.y + (l.x >>> s);
            o.z = l.z - t;
        end
        else begin
            o.x = l.x + (l.y >>> s);
            o.y = l.y - (l.x >>> s);
            o.z = l.z + t;
        end
        return o;
    endfunction

    // micro-rotation
    always_comb
    begin
        ang = e2r_pkg::atan_turn(int'(shift));
        cell_next.rx = rotate(cell_in.rx, shift, ang);
        cell_next.ry = rotate(cell_in.ry, shift, ang);
        cell_next.rz = rotate(cell_in.rz, shift, ang);
        cell_next.vld = cell_in.vld;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else begin
            vld_reg <= cell_next.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg <= cell_next.rx;
        ry_reg <= cell_next.ry;
        rz_reg <= cell_next.rz;
    end

    assign cell_out = {rx_reg, ry_reg, rz_reg, vld_reg};
endmodule

### hw/rtl/e2r_matrix.sv
// ----------------------------------------------------------------------------
// e2r_matrix
// Pipelined closed-form products of R = Rz*Ry*Rx with rounding and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euler_to_rotation_matrix_unit_assert.svh"
module e2r_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  e2r_pkg::cell_t     cell_in,
    output logic               vld,
    output e2r_pkg::out_word_t word
);
    // stage 0: apply fold sign
    e2r_pkg::work_t sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;
    // stage 1: two-factor products
    e2r_pkg::work_t czsy_reg, szsy_reg, czcy_reg, szcy_reg, cysx_reg, cycx_reg;
    e2r_pkg::work_t szcx_reg, szsx_reg, czcx_reg, czsx_reg;
    e2r_pkg::work_t sx1_reg, cx1_reg, nsy1_reg;
    // stage 2: three-factor products
    e2r_pkg::work_t p01_reg, p02_reg, p11_reg, p12_reg;
    e2r_pkg::work_t q01_reg, q02_reg, q11_reg, q12_reg;
    e2r_pkg::work_t a00_reg, a10_reg, a20_reg, a21_reg, a22_reg;
    e2r_pkg::out_word_t word_reg;
    logic [3:0] vld_reg;

    always_ff @(posedge clk)
    begin
        sx_reg <= cell_in.rx.flip ? -cell_in.rx.y : cell_in.rx.y;
        cx_reg <= cell_in.rx.flip ? -cell_in.rx.x : cell_in.rx.x;
        sy_reg <= cell_in.ry.flip ? -cell_in.ry.y : cell_in.ry.y;
        cy_reg <= cell_in.ry.flip ? -cell_in.ry.x : cell_in.ry.x;
        sz_reg <= cell_in.rz.flip ? -cell_in.rz.y : cell_in.rz.y;
        cz_reg <= cell_in.rz.flip ? -cell_in.rz.x : cell_in.rz.x;

        czsy_reg <= e2r_pkg::qmul(cz_reg, sy_reg);
        szsy_reg <= e2r_pkg::qmul(sz_reg, sy_reg);
        czcy_reg <= e2r_pkg::qmul(cz_reg, cy_reg);
        szcy_reg <= e2r_pkg::qmul(sz_reg, cy_reg);
        cysx_reg <= e2r_pkg::qmul(cy_reg, sx_reg);
        cycx_reg <= e2r_pkg::qmul(cy_reg, cx_reg);
        szcx_reg <= e2r_pkg::qmul(sz_reg, cx_reg);
        szsx_reg <= e2r_pkg::qmul(sz_reg, sx_reg);
        czcx_reg <= e2r_pkg::qmul(cz_reg, cx_reg);
        czsx_reg <= e2r_pkg::qmul(cz_reg, sx_reg);
        sx1_reg  <= sx_reg;
        cx1_reg  <= cx_reg;
        nsy1_reg <= -sy_reg;

        p01_reg <= e2r_pkg::qmul(czsy_reg, sx1_reg);
        p02_reg <= e2r_pkg::qmul(czsy_reg, cx1_reg);
        p11_reg <= e2r_pkg::qmul(szsy_reg, sx1_reg);
        p12_reg <= e2r_pkg::qmul(szsy_reg, cx1_reg);
        q01_reg <= szcx_reg;
        q02_reg <= szsx_reg;
        q11_reg <= czcx_reg;
        q12_reg <= czsx_reg;
        a00_reg <= czcy_reg;
        a10_reg <= szcy_reg;
        a20_reg <= nsy1_reg;
        a21_reg <= cysx_reg;
        a22_reg <= cycx_reg;

        // final sums, round and clamp
        word_reg.m00 <= e2r_pkg::to_elem(a00_reg);
        word_reg.m01 <= e2r_pkg::to_elem(p01_reg - q01_reg);
        word_reg.m02 <= e2r_pkg::to_elem(p02_reg + q02_reg);
        word_reg.m10 <= e2r_pkg::to_elem(a10_reg);
        word_reg.m11 <= e2r_pkg::to_elem(p11_reg + q11_reg);
        word_reg.m12 <= e2r_pkg::to_elem(p12_reg - q12_reg);
        word_reg.m20 <= e2r_pkg::to_elem(a20_reg);
        word_reg.m21 <= e2r_pkg::to_elem(a21_reg);
        word_reg.m22 <= e2r_pkg::to_elem(a22_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            vld_reg <= {vld_reg[2:0], cell_in.vld};
        end
    end

    assign vld  = vld_reg[3];
    assign word = word_reg;

    `E2R_ASSERT_NEXT(a_vld_flow, clk, rst_n, cell_in.vld, vld_reg[0])
    `E2R_ASSERT_IMPL(a_m00_range, clk, rst_n,
        vld |-> (word.m00 <= 16'sd16384 && word.m00 >= -16'sd16384))
    `E2R_ASSERT_IMPL(a_m20_range, clk, rst_n,
        vld |-> (word.m20 <= 16'sd16384 && word.m20 >= -16'sd16384))
endmodule

### hw/rtl/euler_to_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_unit
// ZYX Euler angles to a Q1.14 rotation matrix, fully pipelined.
// ----------------------------------------------------------------------------
// channel | signals                  | direction | flow
// in      | start, busy, in_word     | input     | taken when start && !busy
// out     | done, out_word           | output    | one-cycle strobe
//
// One word per cycle; busy is held low. The result passes through the chain
// of CORDIC cells and the four product and rounding stages behind it.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euler_to_rotation_matrix_unit_assert.svh"
module euler_to_rotation_matrix_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  e2r_pkg::in_word_t  in_word,
    output logic               done,
    output e2r_pkg::out_word_t out_word
);
    e2r_pkg::cell_t chain [0:e2r_pkg::CordicStages];

    assign busy = 1'b0;

    // load the head of the chain
    always_comb
    begin
        chain[0].rx  = e2r_pkg::lane_load(in_word.roll_angle);
        chain[0].ry  = e2r_pkg::lane_load(in_word.pitch_angle);
        chain[0].rz  = e2r_pkg::lane_load(in_word.yaw_angle);
        chain[0].vld = start & ~busy;
    end

    genvar g;
    generate
        for (g = 0; g < e2r_pkg::CordicStages; g++) begin : g_cell
            e2r_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (5'(g)),
                .cell_in  (chain[g]),
                .cell_out (chain[g+1])
            );
        end
    endgenerate

    e2r_matrix u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .cell_in (chain[e2r_pkg::CordicStages]),
        .vld     (done),
        .word    (out_word)
    );

    `E2R_ASSERT_IMPL(a_never_busy, clk, rst_n, !busy)
    `E2R_ASSERT_IMPL(a_m22_range, clk, rst_n,
        done |-> (out_word.m22 <= 16'sd16384 && out_word.m22 >= -16'sd16384))
    `E2R_ASSERT_IMPL(a_m11_range, clk, rst_n,
        done |-> (out_word.m11 <= 16'sd16384 && out_word.m11 >= -16'sd16384))
endmodule
